### rtl/core/msb_first_bit_packer_macros.svh
// ----------------------------------------------------------------------------
// msb_first_bit_packer_macros
// assertion macros used by the bit packer top level
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// shared types and constants of the msb-first bit packer
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int WORD_BITS   = 64;
  localparam int BYTE_BITS   = 8;
  localparam int CNT_W       = 7;
  localparam int PEND_W      = 7;
  localparam int PCNT_W      = 3;
  localparam int TOT_W       = 8;
  localparam int NBYTES_W    = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QUEUE_AW + 1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  // one queued job: left-aligned bits and how many bytes to send from the top
  typedef struct packed {
    word_t                 aligned;
    logic [NBYTES_W-1:0]   nbytes;
    logic                  err;
  } mbp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mbp_qstat_t;

endpackage

### rtl/core/mbp_front.sv
// ----------------------------------------------------------------------------
// mbp_front
// accepts items, keeps the pending bits, builds byte jobs for the back end
// ----------------------------------------------------------------------------
module mbp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [mbp_pkg::WORD_BITS-1:0] data_bits,
  input  logic [mbp_pkg::CNT_W-1:0]   bit_count,
  input  mbp_pkg::mbp_qstat_t         qstat,
  output logic                        push,
  output mbp_pkg::mbp_job_t           job
);

  logic [mbp_pkg::PEND_W-1:0]   pending_bits, pending_bits_next;
  logic [mbp_pkg::PCNT_W-1:0]   pending_count, pending_count_next;
  logic                         accept;
  logic [mbp_pkg::TOT_W-1:0]    total;
  logic                         too_long;
  mbp_pkg::word_t               val_mask;
  mbp_pkg::word_t               val_m;
  mbp_pkg::word_t               pend_top;
  logic [mbp_pkg::NBYTES_W-1:0] nbytes;
  logic [2*mbp_pkg::PEND_W-1:0] small_acc;
  logic [mbp_pkg::PCNT_W-1:0]   rem;
  logic [mbp_pkg::PEND_W-1:0]   rem_mask;

  assign in_stall = qstat.full;
  assign accept   = in_valid & ~qstat.full;

  always_comb begin
    for (int i = 0; i < mbp_pkg::WORD_BITS; i++) begin
      val_mask[i] = (mbp_pkg::CNT_W'(i) < bit_count);
    end
  end

  assign val_m    = data_bits & val_mask;
  assign total    = mbp_pkg::TOT_W'(pending_count) + mbp_pkg::TOT_W'(bit_count);
  assign too_long = total > mbp_pkg::TOT_W'(mbp_pkg::WORD_BITS);
  assign nbytes   = total[mbp_pkg::NBYTES_W+2:3];
  assign rem      = total[mbp_pkg::PCNT_W-1:0];
  assign rem_mask = mbp_pkg::PEND_W'((mbp_pkg::TOT_W'(1) << rem) - mbp_pkg::TOT_W'(1));

  // pending bits moved to the top of the word, zero when nothing pends
  assign pend_top = mbp_pkg::word_t'(pending_bits)
                    << (mbp_pkg::TOT_W'(mbp_pkg::WORD_BITS) -
                        mbp_pkg::TOT_W'(pending_count));

  // accumulator for a write that completes no byte (fewer than eight bits)
  assign small_acc = ({{mbp_pkg::PEND_W{1'b0}}, pending_bits} << bit_count[2:0]) |
                     val_m[2*mbp_pkg::PEND_W-1:0];

  always_comb begin
    push               = 1'b0;
    job.aligned        = '0;
    job.nbytes         = mbp_pkg::NBYTES_W'(1);
    job.err            = 1'b0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (accept) begin
      if (req_type == mbp_pkg::REQ_FLUSH) begin
        push               = (pending_count != '0);
        job.aligned        = pend_top;
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else if (bit_count != '0) begin
        if (too_long) begin
          // overflow: one error result, state untouched
          push    = 1'b1;
          job.err = 1'b1;
        end else if (nbytes == '0) begin
          pending_bits_next  = small_acc[mbp_pkg::PEND_W-1:0];
          pending_count_next = rem;
        end else begin
          push               = 1'b1;
          job.nbytes         = nbytes;
          job.aligned        = pend_top |
                               (val_m << (mbp_pkg::TOT_W'(mbp_pkg::WORD_BITS) - total));
          pending_bits_next  = val_m[mbp_pkg::PEND_W-1:0] & rem_mask;
          pending_count_next = rem;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

### rtl/core/mbp_queue.sv
// ----------------------------------------------------------------------------
// mbp_queue
// short job queue between front and back end
// ----------------------------------------------------------------------------
module mbp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mbp_pkg::mbp_job_t   push_job,
  input  logic                pop,
  output mbp_pkg::mbp_job_t   head_job,
  output mbp_pkg::mbp_qstat_t qstat
);

  mbp_pkg::mbp_job_t             entries [mbp_pkg::QUEUE_DEPTH];
  logic [mbp_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [mbp_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [mbp_pkg::QCNT_W-1:0]    count;

  assign qstat.full  = (count == mbp_pkg::QCNT_W'(mbp_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mbp_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mbp_pkg::QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + mbp_pkg::QCNT_W'(1);
        2'b01:   count <= count - mbp_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/mbp_back.sv
// ----------------------------------------------------------------------------
// mbp_back
// sends the bytes of each job from the top, one word per cycle while out_stall is low
// ----------------------------------------------------------------------------
module mbp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  mbp_pkg::mbp_job_t             head_job,
  input  mbp_pkg::mbp_qstat_t           qstat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbp_pkg::BYTE_BITS-1:0] out_byte,
  output logic                          last_byte,
  output logic                          overflow_error
);

  logic                         busy;
  mbp_pkg::word_t               sreg;
  logic [mbp_pkg::NBYTES_W-1:0] left;
  logic                         err;
  logic                         out_accept;
  logic                         done;

  assign out_valid      = busy;
  assign out_byte       = sreg[mbp_pkg::WORD_BITS-1 -: mbp_pkg::BYTE_BITS];
  assign last_byte      = (left == mbp_pkg::NBYTES_W'(1));
  assign overflow_error = err;

  assign out_accept = busy & ~out_stall;
  assign done       = out_accept & last_byte;
  assign pop        = ~qstat.empty & (~busy | done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
      err  <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
      left <= head_job.nbytes;
      err  <= head_job.err;
    end else if (done) begin
      busy <= 1'b0;
    end else if (out_accept) begin
      left <= left - mbp_pkg::NBYTES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sreg <= head_job.aligned;
    end else if (out_accept) begin
      sreg <= sreg << mbp_pkg::BYTE_BITS;
    end
  end

endmodule

### rtl/core/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// packs variable-length bit fields, msb first, into a byte stream
// ----------------------------------------------------------------------------
// A write item appends the low bit_count bits (0 to 64) of data_bits below
// the up to seven pending bits and sends every completed byte, oldest first,
// with last_byte set on the final one. A flush item sends the pending bits
// zero-padded on the right as one byte and clears them. A write that does
// not fit in 64 bits together with the pending bits gives one word with
// overflow_error and last_byte set and out_byte zero, and changes nothing.
// Items that complete no byte (a zero count, an empty flush, a short write)
// give no output word. The front end takes one item per cycle while its
// two-entry job queue has room; the back end sends one word per cycle while
// out_stall is low, so an item makes one word per completed byte (up to eight
// for a full 64-bit write) and the output port sets the sustained rate. An
// item reaches the output through the queue entry and the back-end register.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_macros.svh"

module msb_first_bit_packer (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [mbp_pkg::WORD_BITS-1:0] data_bits,
  input  logic [mbp_pkg::CNT_W-1:0]     bit_count,
  // output words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbp_pkg::BYTE_BITS-1:0] out_byte,
  output logic                          last_byte,
  output logic                          overflow_error
);

  // front to queue
  logic                q_push;
  mbp_pkg::mbp_job_t   q_push_job;
  // queue to back
  logic                q_pop;
  mbp_pkg::mbp_job_t   q_head_job;
  mbp_pkg::mbp_qstat_t q_stat;

  // front: holds pending bits, classifies each item, builds left-aligned jobs
  mbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .data_bits (data_bits),
    .bit_count (bit_count),
    .qstat     (q_stat),
    .push      (q_push),
    .job       (q_push_job)
  );

  // job queue decouples item acceptance from word output
  mbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .qstat    (q_stat)
  );

  // back: shift register emitting the top byte each accepted cycle
  mbp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_job       (q_head_job),
    .qstat          (q_stat),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last_byte      (last_byte),
    .overflow_error (overflow_error)
  );

  // an error word is a lone, zero word
  `MBP_ASSERT_IMP(a_err_word, out_valid && overflow_error, last_byte && out_byte == '0, "error word not lone zero word")

  // never push into a full queue
  `MBP_ASSERT_IMP(a_no_overrun, q_push, !q_stat.full, "job queue overrun")

  // an idle back end picks up a waiting job at once
  `MBP_ASSERT_NEXT(a_pickup, !out_valid && !q_stat.empty, out_valid, "queued job not picked up")

endmodule
